/* rtl/pmsu_pkg.sv */
// Shared types, codes and defaults for the Potts Metropolis site update block.
package pmsu_pkg;

  localparam int DEF_LATTICE_SIDE = 64;
  localparam int DEF_Q_STATES     = 3;

  localparam int COORD_W  = 6;
  localparam int SPIN_W   = 2;
  localparam int RAND_W   = 16;
  localparam int THR_W    = 17;
  localparam int DELTA_W  = 4;
  localparam int COUNT_W  = 14;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // commands
  localparam logic CMD_PROPOSE = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR  = 2'd3;

  localparam logic [THR_W-1:0] THR_ONE_RST   = 17'd20193;
  localparam logic [THR_W-1:0] THR_TWO_RST   = 17'd6233;
  localparam logic [THR_W-1:0] THR_THREE_RST = 17'd1923;
  localparam logic [THR_W-1:0] THR_FOUR_RST  = 17'd593;

  // lattice read sequence: center first, then the four wrapped neighbors
  localparam int RD_SEL_W = 3;
  localparam logic [RD_SEL_W-1:0] RD_CENTER = 3'd0;
  localparam logic [RD_SEL_W-1:0] RD_XP     = 3'd1;
  localparam logic [RD_SEL_W-1:0] RD_XM     = 3'd2;
  localparam logic [RD_SEL_W-1:0] RD_YP     = 3'd3;
  localparam logic [RD_SEL_W-1:0] RD_YM     = 3'd4;
  localparam int NB_READS = 5;

  localparam logic [SPIN_W-1:0] SPIN_RST = 2'd1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic [SPIN_W-1:0]  candidate_spin;
    logic [RAND_W-1:0]  random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [SPIN_W-1:0]         old_spin;
    logic signed [DELTA_W-1:0] bond_change;
    logic [COUNT_W-1:0]        matching_bonds;
    logic [COUNT_W-1:0]        spin_total;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    logic                clear_wr;
    logic                capture;
    logic                rd_en;
    logic [RD_SEL_W-1:0] rd_sel;
    logic                eval;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

/* rtl/pmsu_ctrl.sv */
// Sequencer for lattice clear, site reads, evaluation and result beat.
module pmsu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  pmsu_pkg::dp_status_t  status,
  output pmsu_pkg::ctl_cmd_t    cmd
);
  import pmsu_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [RD_SEL_W-1:0] step;
  logic                last_read;
  logic                eval_go;

  assign req_ready = (state == S_IDLE);
  assign last_read = (step == RD_YM);
  // result register must be free or draining
  assign eval_go   = (state == S_EVAL) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state == S_CLEAR);
    cmd.capture  = (state == S_IDLE) && req_valid;
    cmd.rd_en    = (state == S_READ);
    cmd.rd_sel   = step;
    cmd.eval     = eval_go;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (req_valid) state_next = S_READ;
      S_READ:  if (last_read) state_next = S_EVAL;
      S_EVAL:  if (eval_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= RD_CENTER;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_READ) begin
        step <= last_read ? RD_CENTER : step + RD_SEL_W'(1);
      end
      if (eval_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pmsu_datapath.sv */
// Lattice store, thresholds, counters, bond evaluation and result register.
module pmsu_datapath #(
  parameter int LATTICE_SIDE = pmsu_pkg::DEF_LATTICE_SIDE,
  parameter int Q_STATES     = pmsu_pkg::DEF_Q_STATES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pmsu_pkg::ctl_cmd_t    cmd,
  output pmsu_pkg::dp_status_t  status,
  input  pmsu_pkg::in_item_t    req,
  output pmsu_pkg::out_item_t   rsp,
  input  logic                  cfg_valid,
  input  pmsu_pkg::cfg_write_t  cfg
);
  import pmsu_pkg::*;

  localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;
  localparam int CW    = $clog2(LATTICE_SIDE);
  localparam int AW    = $clog2(SITES);
  localparam logic [CW-1:0] SIDE_MAX = CW'(LATTICE_SIDE - 1);

  // coordinate modulo side: restoring subtract, one step per input bit
  function automatic logic [CW-1:0] wrap_coord(input logic [COORD_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = COORD_W - 1; k >= 0; k--) begin
      if (r >= (LATTICE_SIDE << k)) r = r - (LATTICE_SIDE << k);
    end
    return CW'(r);
  endfunction

  logic [SPIN_W-1:0] lattice [SITES];
  logic [SPIN_W-1:0] spin_tap [NB_READS];

  logic [AW-1:0]      clr_addr;
  logic [THR_W-1:0]   thr_one, thr_two, thr_three, thr_four;
  logic [COUNT_W-1:0] bond_count, spin_sum;

  logic               cmd_q;
  logic [CW-1:0]      x_q, y_q;
  logic [SPIN_W-1:0]  cand_q;
  logic [RAND_W-1:0]  rnd_q;

  logic [CW-1:0]      xp, xm, yp, ym;
  logic [CW-1:0]      rd_x, rd_y;
  logic [AW-1:0]      rd_addr, ctr_addr;

  logic [2:0]         n_cand, n_old;
  logic signed [DELTA_W-1:0] delta;
  logic [1:0]         thr_sel;
  logic [THR_W-1:0]   thr_pick;
  logic               in_range, accept, commit;
  logic [COUNT_W-1:0] bond_next, spin_next;

  assign status.clear_last = (clr_addr == AW'(SITES - 1));

  // wrapped neighbor coordinates
  assign xp = (x_q == SIDE_MAX) ? '0 : x_q + CW'(1);
  assign xm = (x_q == '0) ? SIDE_MAX : x_q - CW'(1);
  assign yp = (y_q == SIDE_MAX) ? '0 : y_q + CW'(1);
  assign ym = (y_q == '0) ? SIDE_MAX : y_q - CW'(1);

  always_comb begin
    rd_x = x_q;
    rd_y = y_q;
    unique case (cmd.rd_sel)
      RD_XP:   rd_x = xp;
      RD_XM:   rd_x = xm;
      RD_YP:   rd_y = yp;
      RD_YM:   rd_y = ym;
      default: begin
        rd_x = x_q;
        rd_y = y_q;
      end
    endcase
  end

  assign rd_addr  = AW'(rd_y) * AW'(LATTICE_SIDE) + AW'(rd_x);
  assign ctr_addr = AW'(y_q) * AW'(LATTICE_SIDE) + AW'(x_q);

  // bond evaluation
  always_comb begin
    n_cand = '0;
    n_old  = '0;
    for (int i = 1; i < NB_READS; i++) begin
      n_cand = n_cand + 3'(spin_tap[i] == cand_q);
      n_old  = n_old + 3'(spin_tap[i] == spin_tap[RD_CENTER]);
    end
  end

  assign delta   = $signed({1'b0, n_cand}) - $signed({1'b0, n_old});
  assign thr_sel = 2'(n_old - n_cand - 3'd1);

  always_comb begin
    unique case (thr_sel)
      REG_THR_ONE:   thr_pick = thr_one;
      REG_THR_TWO:   thr_pick = thr_two;
      REG_THR_THREE: thr_pick = thr_three;
      default:       thr_pick = thr_four;
    endcase
  end

  assign in_range  = ({1'b0, cand_q} < 3'(Q_STATES));
  assign accept    = in_range &&
                     ((cmd_q == CMD_WRITE) || !delta[DELTA_W-1] ||
                      (thr_pick > {1'b0, rnd_q}));
  assign commit    = cmd.eval && accept;
  assign bond_next = bond_count + {{(COUNT_W - DELTA_W){delta[DELTA_W-1]}}, delta};
  assign spin_next = spin_sum + COUNT_W'(cand_q) - COUNT_W'(spin_tap[RD_CENTER]);

  // lattice store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      lattice[clr_addr] <= SPIN_RST;
    end else if (commit) begin
      lattice[ctr_addr] <= cand_q;
    end
    if (cmd.rd_en) begin
      spin_tap[cmd.rd_sel] <= lattice[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      bond_count <= COUNT_W'(2 * SITES);
      spin_sum   <= COUNT_W'(SITES);
      thr_one    <= THR_ONE_RST;
      thr_two    <= THR_TWO_RST;
      thr_three  <= THR_THREE_RST;
      thr_four   <= THR_FOUR_RST;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + AW'(1);
      if (commit) begin
        bond_count <= bond_next;
        spin_sum   <= spin_next;
      end
      if (cfg_valid) begin
        unique case (cfg.index)
          REG_THR_ONE:   thr_one   <= cfg.data;
          REG_THR_TWO:   thr_two   <= cfg.data;
          REG_THR_THREE: thr_three <= cfg.data;
          default:       thr_four  <= cfg.data;
        endcase
      end
    end
  end

  // item capture and result register (payload only)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= req.cmd;
      x_q    <= wrap_coord(req.site_x);
      y_q    <= wrap_coord(req.site_y);
      cand_q <= req.candidate_spin;
      rnd_q  <= req.random_fraction;
    end
    if (cmd.eval) begin
      rsp.old_spin       <= spin_tap[RD_CENTER];
      rsp.status         <= !in_range ? ST_RANGE : (accept ? ST_ACCEPT : ST_REJECT);
      rsp.bond_change    <= in_range ? delta : '0;
      rsp.matching_bonds <= accept ? bond_next : bond_count;
      rsp.spin_total     <= accept ? spin_next : spin_sum;
    end
  end

endmodule

/* rtl/potts_metropolis_site_update.sv */
// Top level of the Potts Metropolis site update block.
// Holds a periodic LATTICE_SIDE x LATTICE_SIDE lattice of Q_STATES-state Potts
// spins with a running matching-bond count and spin sum. Each req beat with an
// in-range candidate spin either proposes a Metropolis move (accepted when the
// bond change is not negative, or when the threshold register for the bonds
// lost is above the random fraction) or writes the site outright; every req
// beat gives exactly one rsp beat with status, old spin, bond change and both
// running totals. After reset the block sweeps the lattice to spin 1, one site
// per cycle; req_ready stays low during that pass, while cfg writes are taken
// at any time. Each item then passes through the accept state, five reads
// (site and four neighbors) through the single lattice read port, and an
// evaluate-and-commit step that loads the rsp register. The rsp register is
// separate, so the next item can start while a result waits; the evaluate
// cycle holds only if the previous result has not yet been taken. Thresholds
// should be written only while idle.
module potts_metropolis_site_update #(
  parameter int LATTICE_SIDE = pmsu_pkg::DEF_LATTICE_SIDE,
  parameter int Q_STATES     = pmsu_pkg::DEF_Q_STATES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  pmsu_pkg::in_item_t                    req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output pmsu_pkg::out_item_t                   rsp,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmsu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmsu_pkg::THR_W-1:0]            cfg_data
);
  import pmsu_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  cfg_write_t cfg;

  // thresholds are plain registers: a cfg beat always lands
  assign cfg_ready = 1'b1;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  pmsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pmsu_datapath #(
    .LATTICE_SIDE (LATTICE_SIDE),
    .Q_STATES     (Q_STATES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg       (cfg)
  );

endmodule
